// File: src/ple_pkg.sv
// ----------------------------------------------------------------------------
// ple_pkg
// Shared request/response types and operation codes for the positional
// list engine.
// ----------------------------------------------------------------------------
`default_nettype none

package ple_pkg;

  // operation codes carried in the mode field
  localparam logic [2:0] MODE_INS_FRONT = 3'd0;
  localparam logic [2:0] MODE_INS_BACK  = 3'd1;
  localparam logic [2:0] MODE_INS_AT    = 3'd2;
  localparam logic [2:0] MODE_DEL_FRONT = 3'd3;
  localparam logic [2:0] MODE_DEL_BACK  = 3'd4;
  localparam logic [2:0] MODE_DEL_AT    = 3'd5;
  localparam logic [2:0] MODE_DUMP      = 3'd6;

  // status codes reported with every result
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_BAD_POS = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;
  localparam logic [1:0] ST_EMPTY   = 2'd3;

  // one input request
  typedef struct packed {
    logic [2:0]         mode;
    logic signed [31:0] value;
    logic [5:0]         position;
  } in_req_t;

  // one result
  typedef struct packed {
    logic [1:0]         status;
    logic [5:0]         entry_count;
    logic signed [31:0] element;
    logic               last;
  } out_rsp_t;

endpackage

`default_nettype wire

// File: src/positional_list_engine.sv
// ----------------------------------------------------------------------------
// positional_list_engine
// Ordered list of signed 32-bit values kept packed in one synchronous
// memory; inserts and deletes shift the tail one entry per cycle.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+---------------------
//  in_     | input     | in_valid / in_ready  | ple_pkg::in_req_t
//  out_    | output    | out_valid / out_ready| ple_pkg::out_rsp_t
//
//  memory: the single memory port pair (one read, one write per cycle)
//  serves the shifts and the dump; the next request is taken once the
//  engine is back in idle, which it reaches in the same cycle that its
//  result enters the output register.
//  reset: synchronous, active low; the list comes up empty, memory contents
//  are not cleared (only entries below the count are ever read).
//  stalls: a finished result waits in the output register while the next
//  request is taken; a dump pauses on each entry until the output frees.
//
`default_nettype none

module positional_list_engine #(
  parameter int CAPACITY = 32
) (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_valid,
  output logic                in_ready,
  input  ple_pkg::in_req_t    in_data,
  output logic                out_valid,
  input  wire                 out_ready,
  output ple_pkg::out_rsp_t   out_data
);

  localparam int AW = (CAPACITY > 2) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int PW = ((CW > 6) ? CW : 6) + 1;

  typedef enum logic [5:0] {
    S_IDLE    = 6'b000001,
    S_SHIFT   = 6'b000010,
    S_PLACE   = 6'b000100,
    S_DUMP_RD = 6'b001000,
    S_DUMP_EM = 6'b010000,
    S_RESP    = 6'b100000
  } state_t;

  state_t             state_r, state_nxt;
  logic [CW-1:0]      occ_r, occ_nxt;
  logic [CW-1:0]      cnt_r, cnt_nxt;
  logic [AW-1:0]      addr_r, addr_nxt;
  logic [AW-1:0]      wr_addr_r, wr_addr_nxt;
  logic               pend_r, pend_nxt;
  logic [AW-1:0]      idx_r, idx_nxt;
  logic signed [31:0] val_r, val_nxt;
  logic               del_r, del_nxt;
  logic [1:0]         status_r, status_nxt;
  logic               out_valid_r, out_valid_nxt;
  ple_pkg::out_rsp_t  out_data_r, out_data_nxt;

  logic signed [31:0] mem [CAPACITY];
  logic signed [31:0] rd_data_r;
  logic               rd_en, wr_en;
  logic [AW-1:0]      rd_addr, wr_addr;
  logic signed [31:0] wr_data;

  logic               accept, slot_free;
  logic [PW-1:0]      pos_w, occ_w, idx_w, addr_w;
  logic               ins_bad, del_bad;

  assign accept    = in_valid && in_ready;
  assign slot_free = !out_valid_r || out_ready;
  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // request decode helpers
  assign pos_w   = PW'(in_data.position);
  assign occ_w   = PW'(occ_r);
  assign addr_w  = PW'(addr_r);
  assign ins_bad = (pos_w == '0) || (pos_w > occ_w + PW'(1));
  assign del_bad = (pos_w == '0) || (pos_w > occ_w);

  // memory port control
  assign rd_en   = ((state_r == S_SHIFT) && (cnt_r != '0)) || (state_r == S_DUMP_RD);
  assign rd_addr = addr_r;
  assign wr_en   = ((state_r == S_SHIFT) && pend_r) || (state_r == S_PLACE);
  assign wr_addr = (state_r == S_PLACE) ? idx_r : wr_addr_r;
  assign wr_data = (state_r == S_PLACE) ? val_r : rd_data_r;

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    occ_nxt       = occ_r;
    cnt_nxt       = cnt_r;
    addr_nxt      = addr_r;
    wr_addr_nxt   = wr_addr_r;
    pend_nxt      = 1'b0;
    idx_nxt       = idx_r;
    val_nxt       = val_r;
    del_nxt       = del_r;
    status_nxt    = status_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    idx_w         = '0;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          val_nxt    = in_data.value;
          status_nxt = ple_pkg::ST_OK;
          case (in_data.mode)
            ple_pkg::MODE_INS_FRONT, ple_pkg::MODE_INS_BACK,
            ple_pkg::MODE_INS_AT: begin
              if (in_data.mode == ple_pkg::MODE_INS_FRONT) begin
                idx_w = '0;
              end else if (in_data.mode == ple_pkg::MODE_INS_BACK) begin
                idx_w = occ_w;
              end else begin
                idx_w = pos_w - PW'(1);
              end
              if (occ_w == PW'(CAPACITY)) begin
                status_nxt = ple_pkg::ST_FULL;
                state_nxt  = S_RESP;
              end else if ((in_data.mode == ple_pkg::MODE_INS_AT) && ins_bad) begin
                status_nxt = ple_pkg::ST_BAD_POS;
                state_nxt  = S_RESP;
              end else begin
                del_nxt   = 1'b0;
                idx_nxt   = AW'(idx_w);
                cnt_nxt   = CW'(occ_w - idx_w);
                addr_nxt  = AW'(occ_w - PW'(1));
                state_nxt = S_SHIFT;
              end
            end
            ple_pkg::MODE_DEL_FRONT, ple_pkg::MODE_DEL_BACK,
            ple_pkg::MODE_DEL_AT: begin
              if (in_data.mode == ple_pkg::MODE_DEL_FRONT) begin
                idx_w = '0;
              end else if (in_data.mode == ple_pkg::MODE_DEL_BACK) begin
                idx_w = occ_w - PW'(1);
              end else begin
                idx_w = pos_w - PW'(1);
              end
              if (occ_r == '0) begin
                status_nxt = ple_pkg::ST_EMPTY;
                state_nxt  = S_RESP;
              end else if ((in_data.mode == ple_pkg::MODE_DEL_AT) && del_bad) begin
                status_nxt = ple_pkg::ST_BAD_POS;
                state_nxt  = S_RESP;
              end else begin
                del_nxt   = 1'b1;
                idx_nxt   = AW'(idx_w);
                cnt_nxt   = CW'(occ_w - PW'(1) - idx_w);
                addr_nxt  = AW'(idx_w + PW'(1));
                state_nxt = S_SHIFT;
              end
            end
            ple_pkg::MODE_DUMP: begin
              if (occ_r == '0) begin
                status_nxt = ple_pkg::ST_EMPTY;
                state_nxt  = S_RESP;
              end else begin
                addr_nxt  = '0;
                state_nxt = S_DUMP_RD;
              end
            end
            default: begin
              state_nxt = S_RESP;
            end
          endcase
        end
      end

      // read one entry, write it one place over on the next cycle
      S_SHIFT: begin
        if (cnt_r != '0) begin
          pend_nxt    = 1'b1;
          cnt_nxt     = cnt_r - CW'(1);
          wr_addr_nxt = del_r ? (addr_r - AW'(1)) : (addr_r + AW'(1));
          addr_nxt    = del_r ? (addr_r + AW'(1)) : (addr_r - AW'(1));
        end else if (!pend_r) begin
          if (del_r) begin
            occ_nxt   = occ_r - CW'(1);
            state_nxt = S_RESP;
          end else begin
            state_nxt = S_PLACE;
          end
        end
      end

      // write the new value into the opened slot
      S_PLACE: begin
        occ_nxt   = occ_r + CW'(1);
        state_nxt = S_RESP;
      end

      S_DUMP_RD: begin
        state_nxt = S_DUMP_EM;
      end

      // emit one entry once the output register frees
      S_DUMP_EM: begin
        if (slot_free) begin
          out_valid_nxt            = 1'b1;
          out_data_nxt.status      = ple_pkg::ST_OK;
          out_data_nxt.entry_count = occ_w[5:0];
          out_data_nxt.element     = rd_data_r;
          out_data_nxt.last        = (addr_w + PW'(1) == occ_w);
          if (addr_w + PW'(1) == occ_w) begin
            state_nxt = S_IDLE;
          end else begin
            addr_nxt  = addr_r + AW'(1);
            state_nxt = S_DUMP_RD;
          end
        end
      end

      // single status result
      S_RESP: begin
        if (slot_free) begin
          out_valid_nxt            = 1'b1;
          out_data_nxt.status      = status_r;
          out_data_nxt.entry_count = occ_w[5:0];
          out_data_nxt.element     = '0;
          out_data_nxt.last        = 1'b1;
          state_nxt                = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      occ_r       <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      occ_r       <= occ_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    cnt_r      <= cnt_nxt;
    addr_r     <= addr_nxt;
    wr_addr_r  <= wr_addr_nxt;
    idx_r      <= idx_nxt;
    val_r      <= val_nxt;
    del_r      <= del_nxt;
    status_r   <= status_nxt;
    out_data_r <= out_data_nxt;
  end

  // list storage
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  // count never exceeds the list size
  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    PW'(occ_r) <= PW'(CAPACITY))
    else $error("entry count above capacity");

  // shift pipeline never reads the entry it writes in the same cycle
  a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
    (rd_en && wr_en) |-> (rd_addr != wr_addr))
    else $error("read and write hit the same entry");

  // count moves by at most one per cycle
  a_occ_step: assert property (@(posedge clk) disable iff (!rst_n)
    (occ_r != $past(occ_r)) |->
      ((PW'(occ_r) == PW'($past(occ_r)) + PW'(1)) ||
       (PW'(occ_r) + PW'(1) == PW'($past(occ_r)))))
    else $error("entry count jumped");

  // no memory write while idle
  a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> !wr_en)
    else $error("memory written while idle");

endmodule

`default_nettype wire

// File: tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives the positional list engine with a short table of directed requests
// and then phases of random requests (fill, drain, mixed). A shadow copy of
// the list predicts every result; each result is compared field by field
// with the oldest prediction. Both channels idle and stall at random.
// ----------------------------------------------------------------------------

module testbench;

  localparam int          CAP          = 32;
  localparam int          CYCLE_LIMIT  = 1_000_000;
  localparam int          DRAIN_CYCLES = 100;
  // mode with no operation behind it
  localparam logic [2:0]  MODE_SPARE   = 3'd7;

  typedef struct {
    ple_pkg::in_req_t  req;
    bit                typed;
    ple_pkg::out_rsp_t rsp;
  } row_t;

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_ready;
  ple_pkg::in_req_t  in_data;
  logic              out_valid;
  logic              out_ready;
  ple_pkg::out_rsp_t out_data;

  // shadow list, front at index 0
  logic [31:0] shadow_list [CAP];
  int          shadow_cnt;

  ple_pkg::out_rsp_t step_rsp [$];
  ple_pkg::out_rsp_t pending_rsp [$];
  row_t              directed_rows [$];
  int                errors;
  int                cycle_count;
  bit                quiet;

  positional_list_engine #(.CAPACITY(CAP)) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // clock
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // watchdog
  initial cycle_count = 0;
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  function automatic ple_pkg::out_rsp_t make_rsp(logic [1:0] st, logic [5:0] cnt,
                                                 logic [31:0] elem, logic fin);
    ple_pkg::out_rsp_t r;
    r.status      = st;
    r.entry_count = cnt;
    r.element     = elem;
    r.last        = fin;
    return r;
  endfunction

  // list behavior: updates the shadow list and fills step_rsp
  task automatic predict_list_op(input ple_pkg::in_req_t r);
    int         idx;
    int         i;
    int         pos;
    bit         take;
    bit         dumped;
    logic [1:0] st;
    step_rsp.delete();
    st     = ple_pkg::ST_OK;
    take   = 1'b0;
    dumped = 1'b0;
    idx    = 0;
    pos    = int'(r.position);
    case (r.mode)
      ple_pkg::MODE_INS_FRONT, ple_pkg::MODE_INS_BACK, ple_pkg::MODE_INS_AT: begin
        if (shadow_cnt >= CAP) begin
          st = ple_pkg::ST_FULL;
        end else if (r.mode == ple_pkg::MODE_INS_FRONT) begin
          take = 1'b1;
        end else if (r.mode == ple_pkg::MODE_INS_BACK) begin
          take = 1'b1;
          idx  = shadow_cnt;
        end else if (pos < 1 || pos > shadow_cnt + 1) begin
          st = ple_pkg::ST_BAD_POS;
        end else begin
          take = 1'b1;
          idx  = pos - 1;
        end
        if (take) begin
          for (i = shadow_cnt; i > idx; i--) shadow_list[i] = shadow_list[i-1];
          shadow_list[idx] = r.value;
          shadow_cnt++;
        end
      end
      ple_pkg::MODE_DEL_FRONT, ple_pkg::MODE_DEL_BACK, ple_pkg::MODE_DEL_AT: begin
        if (shadow_cnt == 0) begin
          st = ple_pkg::ST_EMPTY;
        end else if (r.mode == ple_pkg::MODE_DEL_FRONT) begin
          take = 1'b1;
        end else if (r.mode == ple_pkg::MODE_DEL_BACK) begin
          take = 1'b1;
          idx  = shadow_cnt - 1;
        end else if (pos < 1 || pos > shadow_cnt) begin
          st = ple_pkg::ST_BAD_POS;
        end else begin
          take = 1'b1;
          idx  = pos - 1;
        end
        if (take) begin
          for (i = idx; i + 1 < shadow_cnt; i++) shadow_list[i] = shadow_list[i+1];
          shadow_cnt--;
        end
      end
      ple_pkg::MODE_DUMP: begin
        if (shadow_cnt == 0) begin
          st = ple_pkg::ST_EMPTY;
        end else begin
          dumped = 1'b1;
          for (i = 0; i < shadow_cnt; i++)
            step_rsp.push_back(make_rsp(ple_pkg::ST_OK, shadow_cnt[5:0], shadow_list[i],
                                        (i + 1 == shadow_cnt)));
        end
      end
      default: ;
    endcase
    if (!dumped) step_rsp.push_back(make_rsp(st, shadow_cnt[5:0], 32'd0, 1'b1));
  endtask

  // one directed row; st and cnt only matter for typed rows
  task automatic add_row(input logic [2:0] mode, input logic [31:0] value,
                         input logic [5:0] pos, input bit typed,
                         input logic [1:0] st, input logic [5:0] cnt);
    row_t row;
    row.req.mode     = mode;
    row.req.value    = value;
    row.req.position = pos;
    row.typed        = typed;
    row.rsp          = make_rsp(st, cnt, 32'd0, 1'b1);
    directed_rows.push_back(row);
  endtask

  // random request, weighted by phase
  function automatic ple_pkg::in_req_t random_req(int ins_pct, int del_pct);
    ple_pkg::in_req_t r;
    int               k;
    int               top;
    k = $urandom_range(0, 99);
    if (k < ins_pct) begin
      r.mode = 3'($urandom_range(0, 2)) + ple_pkg::MODE_INS_FRONT;
    end else if (k < ins_pct + del_pct) begin
      r.mode = 3'($urandom_range(0, 2)) + ple_pkg::MODE_DEL_FRONT;
    end else if (k < ins_pct + del_pct + 3) begin
      r.mode = MODE_SPARE;
    end else begin
      r.mode = ple_pkg::MODE_DUMP;
    end
    case ($urandom_range(0, 9))
      0:       r.value = 32'h8000_0000;
      1:       r.value = 32'h7fff_ffff;
      2:       r.value = 32'hffff_ffff;
      default: r.value = $urandom;
    endcase
    // mostly legal positions, some anywhere in the field
    if ($urandom_range(0, 7) == 0) begin
      r.position = 6'($urandom_range(0, 63));
    end else begin
      top = (r.mode == ple_pkg::MODE_INS_AT) ? shadow_cnt + 1 : shadow_cnt;
      if (top < 1) top = 1;
      r.position = 6'($urandom_range(1, top));
    end
    return r;
  endfunction

  // request side: random gap, hold until accepted, then predict
  task automatic send_req(input ple_pkg::in_req_t r, input bit typed,
                          input ple_pkg::out_rsp_t typed_rsp);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= r;
    do @(posedge clk); while (!in_ready);
    predict_list_op(r);
    if (typed) pending_rsp.push_back(typed_rsp);
    else foreach (step_rsp[j]) pending_rsp.push_back(step_rsp[j]);
  endtask

  // stop requesting and wait until every expected result has come
  task automatic wait_all_results();
    in_valid <= 1'b0;
    while (pending_rsp.size() != 0) @(posedge clk);
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      errors++;
    end
  endtask

  // result side: compare each accepted result, then draw the next stall
  initial begin : result_side
    ple_pkg::out_rsp_t want;
    int                stall;
    stall = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready) begin
        if (pending_rsp.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %0h", $time, out_data);
          errors++;
        end else begin
          want = pending_rsp.pop_front();
          check_field("status", 32'(want.status), 32'(out_data.status));
          check_field("entry_count", 32'(want.entry_count), 32'(out_data.entry_count));
          check_field("element", want.element, out_data.element);
          check_field("last", 32'(want.last), 32'(out_data.last));
        end
        stall = quiet ? 0 : $urandom_range(0, 19);
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        stall--;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // main sequence
  initial begin : stimulus
    int                p;
    int                n;
    int                ins_pct;
    int                del_pct;
    ple_pkg::out_rsp_t none_rsp;
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_data    = '0;
    out_ready  = 1'b0;
    errors     = 0;
    quiet      = 1'b0;
    shadow_cnt = 0;
    none_rsp   = '0;

    // directed table: empty list, bad positions, extremes, middle edits
    add_row(ple_pkg::MODE_DUMP,      32'd0,         6'd0,  1'b1, ple_pkg::ST_EMPTY,   6'd0);
    add_row(ple_pkg::MODE_DEL_FRONT, 32'd0,         6'd0,  1'b1, ple_pkg::ST_EMPTY,   6'd0);
    add_row(ple_pkg::MODE_DEL_BACK,  32'd0,         6'd0,  1'b1, ple_pkg::ST_EMPTY,   6'd0);
    add_row(ple_pkg::MODE_DEL_AT,    32'd0,         6'd1,  1'b1, ple_pkg::ST_EMPTY,   6'd0);
    add_row(ple_pkg::MODE_INS_AT,    32'd9,         6'd0,  1'b1, ple_pkg::ST_BAD_POS, 6'd0);
    add_row(ple_pkg::MODE_INS_AT,    32'd9,         6'd2,  1'b1, ple_pkg::ST_BAD_POS, 6'd0);
    add_row(MODE_SPARE,              32'd0,         6'd0,  1'b1, ple_pkg::ST_OK,      6'd0);
    add_row(ple_pkg::MODE_INS_AT,    32'h7fff_ffff, 6'd1,  1'b1, ple_pkg::ST_OK,      6'd1);
    add_row(ple_pkg::MODE_INS_FRONT, 32'h8000_0000, 6'd0,  1'b1, ple_pkg::ST_OK,      6'd2);
    add_row(ple_pkg::MODE_INS_BACK,  32'hffff_ffff, 6'd63, 1'b1, ple_pkg::ST_OK,      6'd3);
    add_row(ple_pkg::MODE_INS_AT,    32'd0,         6'd4,  1'b1, ple_pkg::ST_OK,      6'd4);
    add_row(ple_pkg::MODE_INS_AT,    32'h1234_5678, 6'd2,  1'b0, ple_pkg::ST_OK,      6'd0);
    add_row(ple_pkg::MODE_DUMP,      32'd0,         6'd0,  1'b0, ple_pkg::ST_OK,      6'd0);
    add_row(ple_pkg::MODE_DEL_AT,    32'd0,         6'd0,  1'b1, ple_pkg::ST_BAD_POS, 6'd5);
    add_row(ple_pkg::MODE_DEL_AT,    32'd0,         6'd6,  1'b1, ple_pkg::ST_BAD_POS, 6'd5);
    add_row(ple_pkg::MODE_DEL_AT,    32'd0,         6'd63, 1'b1, ple_pkg::ST_BAD_POS, 6'd5);
    add_row(ple_pkg::MODE_INS_AT,    32'd5,         6'd63, 1'b1, ple_pkg::ST_BAD_POS, 6'd5);
    add_row(ple_pkg::MODE_DEL_AT,    32'd0,         6'd3,  1'b0, ple_pkg::ST_OK,      6'd0);
    add_row(ple_pkg::MODE_DUMP,      32'd0,         6'd0,  1'b0, ple_pkg::ST_OK,      6'd0);
    add_row(ple_pkg::MODE_DEL_FRONT, 32'd0,         6'd0,  1'b1, ple_pkg::ST_OK,      6'd3);
    add_row(ple_pkg::MODE_DEL_BACK,  32'd0,         6'd0,  1'b1, ple_pkg::ST_OK,      6'd2);
    add_row(MODE_SPARE,              32'hffff_ffff, 6'd63, 1'b1, ple_pkg::ST_OK,      6'd2);
    add_row(ple_pkg::MODE_DUMP,      32'd0,         6'd0,  1'b0, ple_pkg::ST_OK,      6'd0);

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i])
      send_req(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].rsp);

    // hold requests back until the block has drained
    wait_all_results();

    // random phases: fill, mixed, fill, drain, mixed
    for (p = 0; p < 5; p++) begin
      case (p)
        0, 2:    begin ins_pct = 85; del_pct = 5;  end
        3:       begin ins_pct = 10; del_pct = 80; end
        default: begin ins_pct = 45; del_pct = 42; end
      endcase
      quiet = ($urandom_range(0, 3) == 0);
      for (n = 0; n < 40; n++) send_req(random_req(ins_pct, del_pct), 1'b0, none_rsp);
      if ($urandom_range(0, 1) == 0) wait_all_results();
    end

    quiet = 1'b0;
    wait_all_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// File: files.f
src/ple_pkg.sv
src/positional_list_engine.sv
tb/testbench.sv
